// ===== rtl/iba_pkg.sv =====
// Shared constants, codes and controller/datapath command and status types
// for the inode block allocator. No dependencies.
`default_nettype none
package iba_pkg;
	localparam int NUM_BLOCKS      = 128;
	localparam int MAX_FILE_BLOCKS = 8;
	localparam int MAX_FILES       = 16;
	localparam int NAME_BYTES      = 16;

	localparam int NAME_W    = 8 * NAME_BYTES;
	localparam int HALF_W    = 64;
	localparam int BLK_W     = $clog2(NUM_BLOCKS);
	localparam int FCNT_W    = $clog2(NUM_BLOCKS + 1);
	localparam int INODE_W   = $clog2(MAX_FILES);
	localparam int KCNT_W    = $clog2(MAX_FILE_BLOCKS + 1);
	localparam int KIDX_W    = $clog2(MAX_FILE_BLOCKS);
	localparam int PTR_DEPTH = MAX_FILES * MAX_FILE_BLOCKS;
	localparam int PTR_AW    = INODE_W + KIDX_W;

	localparam int FUNC_W   = 2;
	localparam int SIZE_W   = 4;
	localparam int BIDX_W   = 3;
	localparam int STATUS_W = 3;

	typedef enum logic [FUNC_W-1:0] {
		FN_CREATE = 2'd0,
		FN_DELETE = 2'd1,
		FN_MAP    = 2'd2,
		FN_RSVD   = 2'd3
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_TOO_BIG   = 3'd1,
		ST_NO_SPACE  = 3'd2,
		ST_DUPLICATE = 3'd3,
		ST_NO_INODE  = 3'd4,
		ST_NOT_FOUND = 3'd5,
		ST_BAD_INDEX = 3'd6
	} status_t;

	// controller -> datapath
	typedef struct packed {
		logic    load_req;
		logic    scan_step;
		logic    alloc_start;
		logic    alloc_step;
		logic    del_start;
		logic    del_rd;
		logic    del_clr;
		logic    del_finish;
		logic    map_rd;
		logic    out_load;
		status_t out_status;
		logic    out_inode;
		logic    out_disk;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		func_t func;
		logic  too_big;
		logic  no_space;
		logic  scan_last;
		logic  found;
		logic  has_free;
		logic  alloc_done;
		logic  del_done;
		logic  bad_index;
	} sts_t;
endpackage
`default_nettype wire

// ===== rtl/iba_chan_if.sv =====
// Valid/ready channel interfaces for request and response beats.
// Depends on nothing but plain logic types.
`default_nettype none
interface iba_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [63:0] name_low;
	logic [63:0] name_high;
	logic [3:0]  size_blocks;
	logic [2:0]  block_index;
	modport source (output valid, func, name_low, name_high, size_blocks, block_index,
		input ready);
	modport sink (input valid, func, name_low, name_high, size_blocks, block_index,
		output ready);
endinterface

interface iba_rsp_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;
	logic [3:0] inode_index;
	logic [6:0] disk_block;
	modport source (output valid, status, inode_index, disk_block, input ready);
	modport sink (input valid, status, inode_index, disk_block, output ready);
endinterface
`default_nettype wire

// ===== rtl/iba_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none
module iba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[waddr] <= wdata;
		end
		if (rd_en) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

// ===== rtl/iba_ctrl.sv =====
// Sequencing state machine of the allocator: walks each request through
// check, inode scan, block allocation, release or lookup, and response. Uses iba_pkg.
`default_nettype none
module iba_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	input  wire iba_pkg::sts_t sts,
	output iba_pkg::cmd_t      cmd
);
	import iba_pkg::*;

	typedef enum logic [9:0] {
		S_IDLE     = 10'b00_0000_0001,
		S_CHECK    = 10'b00_0000_0010,
		S_SCAN     = 10'b00_0000_0100,
		S_DECIDE   = 10'b00_0000_1000,
		S_ALLOC    = 10'b00_0001_0000,
		S_DEL_RD   = 10'b00_0010_0000,
		S_DEL_CLR  = 10'b00_0100_0000,
		S_MAP_WAIT = 10'b00_1000_0000,
		S_DONE     = 10'b01_0000_0000,
		S_SPARE    = 10'b10_0000_0000
	} state_t;

	state_t  state_q, state_d;
	logic    out_valid_q;
	status_t res_status_q, done_status;
	logic    res_inode_q, res_disk_q, done_inode, done_disk, done_go;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = out_valid_q;

	// next state and datapath commands
	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		done_go     = 1'b0;
		done_status = ST_OK;
		done_inode  = 1'b0;
		done_disk   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load_req = 1'b1;
					state_d      = S_CHECK;
				end
			end
			S_CHECK: begin
				priority if (sts.func == FN_RSVD) begin
					done_go     = 1'b1;
					done_status = ST_BAD_INDEX;
				end else if (sts.func == FN_CREATE && sts.too_big) begin
					done_go     = 1'b1;
					done_status = ST_TOO_BIG;
				end else if (sts.func == FN_CREATE && sts.no_space) begin
					done_go     = 1'b1;
					done_status = ST_NO_SPACE;
				end else begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_last) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				priority if (sts.func == FN_CREATE && sts.found) begin
					done_go     = 1'b1;
					done_status = ST_DUPLICATE;
				end else if (sts.func == FN_CREATE && !sts.has_free) begin
					done_go     = 1'b1;
					done_status = ST_NO_INODE;
				end else if (sts.func == FN_CREATE) begin
					cmd.alloc_start = 1'b1;
					state_d         = S_ALLOC;
				end else if (!sts.found) begin
					done_go     = 1'b1;
					done_status = ST_NOT_FOUND;
				end else if (sts.func == FN_DELETE) begin
					cmd.del_start = 1'b1;
					state_d       = S_DEL_RD;
				end else if (sts.bad_index) begin
					done_go     = 1'b1;
					done_status = ST_BAD_INDEX;
				end else begin
					cmd.map_rd = 1'b1;
					state_d    = S_MAP_WAIT;
				end
			end
			S_ALLOC: begin
				if (sts.alloc_done) begin
					done_go    = 1'b1;
					done_inode = 1'b1;
				end else begin
					cmd.alloc_step = 1'b1;
				end
			end
			S_DEL_RD: begin
				if (sts.del_done) begin
					cmd.del_finish = 1'b1;
					done_go        = 1'b1;
					done_inode     = 1'b1;
				end else begin
					cmd.del_rd = 1'b1;
					state_d    = S_DEL_CLR;
				end
			end
			S_DEL_CLR: begin
				cmd.del_clr = 1'b1;
				state_d     = S_DEL_RD;
			end
			S_MAP_WAIT: begin
				done_go    = 1'b1;
				done_inode = 1'b1;
				done_disk  = 1'b1;
			end
			S_DONE: begin
				if (!out_valid_q || rsp_ready) begin
					cmd.out_load   = 1'b1;
					cmd.out_status = res_status_q;
					cmd.out_inode  = res_inode_q;
					cmd.out_disk   = res_disk_q;
					state_d        = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
		if (done_go) begin
			state_d = S_DONE;
		end
	end

	// state, pending result code and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			out_valid_q  <= 1'b0;
			res_status_q <= ST_OK;
			res_inode_q  <= 1'b0;
			res_disk_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (done_go) begin
				res_status_q <= done_status;
				res_inode_q  <= done_inode;
				res_disk_q   <= done_disk;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

// ===== rtl/iba_dp.sv =====
// Allocator datapath: request registers, block map, free count, inode table,
// pointer RAM, scan and allocation counters, response register.
// Uses iba_pkg and iba_ram.
`default_nettype none
module iba_dp (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire iba_pkg::cmd_t                     cmd,
	output iba_pkg::sts_t                          sts,
	input  wire logic [iba_pkg::FUNC_W-1:0]        req_func,
	input  wire logic [iba_pkg::HALF_W-1:0]        req_name_low,
	input  wire logic [iba_pkg::HALF_W-1:0]        req_name_high,
	input  wire logic [iba_pkg::SIZE_W-1:0]        req_size,
	input  wire logic [iba_pkg::BIDX_W-1:0]        req_bidx,
	output logic      [iba_pkg::STATUS_W-1:0]      rsp_status,
	output logic      [iba_pkg::INODE_W-1:0]       rsp_inode,
	output logic      [iba_pkg::BLK_W-1:0]         rsp_disk
);
	import iba_pkg::*;

	// request beat
	func_t             func_q;
	logic [NAME_W-1:0] name_q;
	logic [SIZE_W-1:0] size_q;
	logic [BIDX_W-1:0] bidx_q;

	// file system state
	logic [NUM_BLOCKS-1:0] blk_used_q;
	logic [FCNT_W-1:0]     free_cnt_q;
	logic [MAX_FILES-1:0]  inode_used_q;
	logic [NAME_W-1:0]     inode_name_q [MAX_FILES];
	logic [SIZE_W-1:0]     inode_size_q [MAX_FILES];

	// scan and walk counters
	logic [INODE_W-1:0] scan_q, slot_q, free_q;
	logic               found_q, free_ok_q;
	logic [KCNT_W-1:0]  k_q;
	logic [BLK_W-1:0]   b_q;

	logic              name_hit, take_blk, rd_en;
	logic [PTR_AW-1:0] waddr, raddr;
	logic [BLK_W-1:0]  rdata;
	logic [SIZE_W-1:0] slot_size;

	assign name_hit  = inode_used_q[scan_q] && (inode_name_q[scan_q] == name_q);
	assign take_blk  = cmd.alloc_step && !blk_used_q[b_q];
	assign slot_size = inode_size_q[slot_q];

	// status toward the controller
	assign sts.func       = func_q;
	assign sts.too_big    = size_q > SIZE_W'(MAX_FILE_BLOCKS);
	assign sts.no_space   = FCNT_W'(size_q) > free_cnt_q;
	assign sts.scan_last  = scan_q == INODE_W'(MAX_FILES - 1);
	assign sts.found      = found_q;
	assign sts.has_free   = free_ok_q;
	assign sts.alloc_done = k_q == KCNT_W'(size_q);
	assign sts.del_done   = k_q == KCNT_W'(slot_size);
	assign sts.bad_index  = SIZE_W'(bidx_q) >= slot_size;

	// pointer RAM addressing
	assign waddr = {slot_q, k_q[KIDX_W-1:0]};
	assign raddr = cmd.map_rd ? {slot_q, KIDX_W'(bidx_q)} : {slot_q, k_q[KIDX_W-1:0]};
	assign rd_en = cmd.map_rd || cmd.del_rd;

	iba_ram #(
		.WIDTH(BLK_W),
		.DEPTH(PTR_DEPTH)
	) u_ptr_ram (
		.clk  (clk),
		.wr_en(take_blk),
		.waddr(waddr),
		.wdata(b_q),
		.rd_en(rd_en),
		.raddr(raddr),
		.rdata(rdata)
	);

	// request capture, inode metadata, response payload
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			func_q <= func_t'(req_func);
			name_q <= {req_name_high, req_name_low};
			size_q <= req_size;
			bidx_q <= req_bidx;
		end
		if (cmd.alloc_start) begin
			inode_name_q[free_q] <= name_q;
			inode_size_q[free_q] <= size_q;
		end
		if (cmd.out_load) begin
			rsp_status <= cmd.out_status;
			rsp_inode  <= cmd.out_inode ? slot_q : '0;
			rsp_disk   <= cmd.out_disk ? rdata : '0;
		end
	end

	// counters, block map and inode valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blk_used_q   <= '0;
			free_cnt_q   <= FCNT_W'(NUM_BLOCKS);
			inode_used_q <= '0;
			scan_q       <= '0;
			slot_q       <= '0;
			free_q       <= '0;
			found_q      <= 1'b0;
			free_ok_q    <= 1'b0;
			k_q          <= '0;
			b_q          <= '0;
		end else begin
			if (cmd.load_req) begin
				scan_q    <= '0;
				found_q   <= 1'b0;
				free_ok_q <= 1'b0;
			end
			// inode scan: lowest matching used inode, lowest free inode
			if (cmd.scan_step) begin
				scan_q <= scan_q + 1'b1;
				if (name_hit && !found_q) begin
					found_q <= 1'b1;
					slot_q  <= scan_q;
				end
				if (!inode_used_q[scan_q] && !free_ok_q) begin
					free_ok_q <= 1'b1;
					free_q    <= scan_q;
				end
			end
			if (cmd.alloc_start) begin
				slot_q               <= free_q;
				inode_used_q[free_q] <= 1'b1;
				k_q                  <= '0;
				b_q                  <= '0;
			end
			// first-fit allocation, one block index per cycle
			if (cmd.alloc_step) begin
				b_q <= b_q + 1'b1;
				if (take_blk) begin
					blk_used_q[b_q] <= 1'b1;
					free_cnt_q      <= free_cnt_q - 1'b1;
					k_q             <= k_q + 1'b1;
				end
			end
			if (cmd.del_start) begin
				k_q <= '0;
			end
			if (cmd.del_clr) begin
				blk_used_q[rdata] <= 1'b0;
				free_cnt_q        <= free_cnt_q + 1'b1;
				k_q               <= k_q + 1'b1;
			end
			if (cmd.del_finish) begin
				inode_used_q[slot_q] <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

// ===== rtl/inode_block_allocator.sv =====
// Inode block allocator top level: controller plus datapath.
// Uses iba_pkg, iba_chan_if, iba_ctrl and iba_dp.
//
// Usage: request beats (func, name, size_blocks, block_index) arrive on the
// req channel; every request produces exactly one response beat (status,
// inode_index, disk_block) on the rsp channel, in order.
// One request is worked at a time. Steps from accept to response valid:
//   reserved code, too big, no space: the check alone
//   other requests: check, then a scan of all 16 inodes (one inode per cycle), plus
//   create: disk blocks examined in order, up to the highest block taken
//           (first fit over the block map)
//   delete: per freed block, a pointer RAM read, then a map update
//   map:    a pointer RAM read.
// The block map is 128 flip-flops with a running free count; the inode names
// and sizes are flip-flop tables, the block pointers sit in a small RAM.
// Reset empties the file system: all blocks free, all inodes unused.
// The response sits in an output register; req.ready rises again once it is
// loaded, so the next request runs while the last response waits. A stalled
// receiver holds the response steady and blocks only the next completion.
`default_nettype none
module inode_block_allocator (
	input wire logic clk,
	input wire logic arst_n,
	iba_req_if.sink   req,
	iba_rsp_if.source rsp
);
	import iba_pkg::*;

	cmd_t cmd;
	sts_t sts;

	iba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req.valid),
		.req_ready(req.ready),
		.rsp_valid(rsp.valid),
		.rsp_ready(rsp.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	iba_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.req_func     (req.func),
		.req_name_low (req.name_low),
		.req_name_high(req.name_high),
		.req_size     (req.size_blocks),
		.req_bidx     (req.block_index),
		.rsp_status   (rsp.status),
		.rsp_inode    (rsp.inode_index),
		.rsp_disk     (rsp.disk_block)
	);
endmodule
`default_nettype wire

// ===== rtl/iba_checker.sv =====
// Port-level checks of the allocator response channel, bound to the top.
// Uses iba_pkg status codes.
`default_nettype none
module iba_port_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       req_valid,
	input wire logic       req_ready,
	input wire logic       rsp_valid,
	input wire logic       rsp_ready,
	input wire logic [2:0] status,
	input wire logic [3:0] inode_index,
	input wire logic [6:0] disk_block
);
	import iba_pkg::*;

	// a stalled response beat stays up and unchanged
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(status)
			&& $stable(inode_index) && $stable(disk_block))
		else $error("response beat dropped or changed while stalled");

	// only defined status codes
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> status != 3'd7)
		else $error("undefined status code");

	// failed requests report zero inode and disk block
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != ST_OK |-> inode_index == '0 && disk_block == '0)
		else $error("error response carries nonzero fields");

	// a request accepted now cannot be answered in the next cycle
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && !rsp_valid |=> !rsp_valid)
		else $error("response appeared too early");
endmodule

bind inode_block_allocator iba_port_checker u_iba_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.status     (rsp.status),
	.inode_index(rsp.inode_index),
	.disk_block (rsp.disk_block)
);
`default_nettype wire
